/* design/lcpw_pkg.sv */
// ============================================================================
// lcpw_pkg: shared types and constants for the pinned-window LRU slot cache
// Holds the entry word layout, the controller states, the action codes and
// the helper functions for the circular window test.
// ============================================================================
package lcpw_pkg;

    // Geometry of the cache.
    localparam int ENTRIES     = 13;
    localparam int WINDOW_SPAN = 9;
    localparam int HALF_SPAN   = WINDOW_SPAN / 2;
    localparam int IDX_W       = $clog2(ENTRIES);

    // Field widths.
    localparam int ACTION_W = 2;
    localparam int ALBUM_W  = 12;
    localparam int COUNT_W  = 13;
    localparam int SLOT_W   = 6;
    localparam int AGE_W    = 32;
    localparam int DATA_W   = 32;
    localparam int PADDR_W  = 2;

    // The modulo unit retires this many dividend bits per cycle.
    localparam int MOD_STEPS  = 4;
    localparam int MOD_CHUNKS = ALBUM_W / MOD_STEPS;
    localparam int MOD_CNT_W  = $clog2(MOD_CHUNKS);

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PROBE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DROP   = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_FLUSH  = 2'd3;

    // Register addresses.
    localparam logic [PADDR_W-1:0] ADDR_ALBUM_COUNT = 2'd0;

    // One entry of the slot memory.
    typedef struct packed {
        logic [ALBUM_W-1:0] album;
        logic               has_art;
        logic [AGE_W-1:0]   age;
    } ent_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMOD,
        ST_READ,
        ST_EVAL,
        ST_EMOD,
        ST_JUDGE,
        ST_WRITE,
        ST_DONE
    } state_t;

    // A few restoring remainder steps: shift in dividend bits, subtract n when it fits.
    function automatic logic [COUNT_W-1:0] mod_step(
        input logic [COUNT_W-1:0]   r,
        input logic [MOD_STEPS-1:0] bits,
        input logic [COUNT_W-1:0]   n
    );
        logic [COUNT_W:0] t;
        t = {1'b0, r};
        for (int k = 0; k < MOD_STEPS; k++)
        begin
            t = {t[COUNT_W-1:0], bits[MOD_STEPS-1-k]};
            if (t >= {1'b0, n})
            begin
                t = t - {1'b0, n};
            end
        end
        return t[COUNT_W-1:0];
    endfunction

    // Circular window test on residues that are already reduced modulo n.
    function automatic logic in_window(
        input logic [COUNT_W-1:0] ra,
        input logic [COUNT_W-1:0] rc,
        input logic [COUNT_W-1:0] n
    );
        logic [COUNT_W:0] d;
        logic [COUNT_W:0] nx;
        nx = {1'b0, n};
        if (ra >= rc)
        begin
            d = {1'b0, ra} - {1'b0, rc};
        end
        else
        begin
            d = {1'b0, ra} + nx - {1'b0, rc};
        end
        return (n != '0) &&
               ((d <= (COUNT_W+1)'(HALF_SPAN)) ||
                (nx <= (COUNT_W+1)'(HALF_SPAN)) ||
                (d >= nx - (COUNT_W+1)'(HALF_SPAN)));
    endfunction

endpackage

/* design/lru_cache_with_pinned_window_top.sv */
// ============================================================================
// lru_cache_with_pinned_window_top: LRU slot cache with a pinned window
// Fully associative cache of item slots with least-recently-used eviction
// that spares entries near the current centre item.
// ============================================================================
//
// Usage
//   A transaction is issued by raising start while busy is low; action,
//   album, centre and has_art are sampled at that edge. Exactly one result
//   comes back per transaction: done is high for one cycle with hit, slot,
//   evicted_valid, evicted_album and repaint. The receiver cannot stall, so
//   the result is simply presented for that one cycle.
//   A flush clears every valid bit and goes straight to the result. A probe
//   scans the slot memory one entry at a time until the first hit or the
//   last entry. A lookup and a drop first reduce the centre modulo
//   album_count. A lookup then judges an invalid entry directly, reduces a
//   valid one it passes before judging it, stops at the entry that hits,
//   and ends by writing the hit or victim slot. A drop reduces and removes
//   each valid entry without art, keeps the rest, and ends with the result.
//   The scan is set by the single read port of the entry memory, walked one
//   entry at a time, and by the shared modulo unit at 4 bits per cycle. One
//   transaction is in flight at a time; busy stays high until done. The user
//   writes album_count over the APB port only while the block is idle; the
//   block does not enforce it. Reset empties the cache, zeroes the ages and
//   the use counter and sets album_count to 1. Entry words that were never
//   written read as zero.
//
module lru_cache_with_pinned_window_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [lcpw_pkg::ACTION_W-1:0] action,
    input  logic [lcpw_pkg::ALBUM_W-1:0]  album,
    input  logic [lcpw_pkg::ALBUM_W-1:0]  centre,
    input  logic                         has_art,
    output logic                         done,
    output logic                         hit,
    output logic [lcpw_pkg::SLOT_W-1:0]   slot,
    output logic                         evicted_valid,
    output logic [lcpw_pkg::ALBUM_W-1:0]  evicted_album,
    output logic                         repaint,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lcpw_pkg::PADDR_W-1:0]  paddr,
    input  logic [lcpw_pkg::DATA_W-1:0]   pwdata,
    output logic [lcpw_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import lcpw_pkg::*;

    // Control state.
    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [ENTRIES-1:0]   valid_reg, valid_next;
    logic [ENTRIES-1:0]   written_reg;
    logic [AGE_W-1:0]     counter_reg, counter_next;
    logic [COUNT_W-1:0]   album_count_reg;
    logic [MOD_CNT_W-1:0] mod_cnt_reg, mod_cnt_next;

    // Latched transaction and working values.
    logic [ACTION_W-1:0]  act_reg, act_next;
    logic [ALBUM_W-1:0]   album_reg, album_next;
    logic [ALBUM_W-1:0]   centre_reg, centre_next;
    logic                 art_reg, art_next;
    logic [COUNT_W-1:0]   mod_r_reg, mod_r_next;
    logic [COUNT_W-1:0]   rc_reg, rc_next;
    logic                 have_best_reg, have_best_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [AGE_W-1:0]     best_age_reg, best_age_next;
    logic                 best_valid_reg, best_valid_next;
    logic [ALBUM_W-1:0]   best_album_reg, best_album_next;
    logic [ALBUM_W-1:0]   e0_album_reg, e0_album_next;

    // Result registers.
    logic                 hit_reg, hit_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic                 ev_valid_reg, ev_valid_next;
    logic [ALBUM_W-1:0]   ev_album_reg, ev_album_next;
    logic                 repaint_reg, repaint_next;

    // Entry memory and its read path.
    ent_t                 ent_mem [ENTRIES];
    ent_t                 rdata_reg;
    logic                 rd_written_reg;
    ent_t                 rd;
    logic                 mem_we;
    ent_t                 wr_word;
    logic [IDX_W-1:0]     wr_addr;

    // Helper signals.
    logic                 accept;
    logic                 cfg_write;
    logic                 rd_valid;
    logic                 match;
    logic                 last;
    logic                 advance;
    logic                 pinned;
    logic [ALBUM_W-1:0]   mod_div;
    logic [ALBUM_W-1:0]   mod_shift;
    logic [COUNT_W-1:0]   mod_val;
    logic                 mod_last;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_ALBUM_COUNT);
    assign prdata    = (paddr == ADDR_ALBUM_COUNT) ? DATA_W'(album_count_reg) : '0;

    // Words that were never written read as their reset value.
    assign rd       = rd_written_reg ? rdata_reg : '0;
    assign rd_valid = valid_reg[idx_reg];
    assign match    = rd_valid && (rd.album == album_reg);
    assign last     = (idx_reg == IDX_W'(ENTRIES - 1));

    // Shared modulo unit: the centre in its own state, else the entry item.
    assign mod_div   = (state_reg == ST_CMOD) ? centre_reg : rd.album;
    assign mod_shift = mod_div << (MOD_STEPS * 32'(mod_cnt_reg));
    assign mod_val   = mod_step(mod_r_reg, mod_shift[ALBUM_W-1 -: MOD_STEPS], album_count_reg);
    assign mod_last  = (mod_cnt_reg == MOD_CNT_W'(MOD_CHUNKS - 1));

    assign pinned = rd_valid && in_window(mod_r_reg, rc_reg, album_count_reg);

    // Write port: refresh the hit entry or fill the victim slot.
    assign wr_addr         = slot_reg[IDX_W-1:0];
    assign wr_word.album   = hit_reg ? rd.album : album_reg;
    assign wr_word.has_art = hit_reg ? rd.has_art : art_reg;
    assign wr_word.age     = counter_reg + AGE_W'(1);

    // Next state and datapath updates.
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        valid_next      = valid_reg;
        counter_next    = counter_reg;
        mod_cnt_next    = mod_cnt_reg;
        act_next        = act_reg;
        album_next      = album_reg;
        centre_next     = centre_reg;
        art_next        = art_reg;
        mod_r_next      = mod_r_reg;
        rc_next         = rc_reg;
        have_best_next  = have_best_reg;
        best_idx_next   = best_idx_reg;
        best_age_next   = best_age_reg;
        best_valid_next = best_valid_reg;
        best_album_next = best_album_reg;
        e0_album_next   = e0_album_reg;
        hit_next        = hit_reg;
        slot_next       = slot_reg;
        ev_valid_next   = ev_valid_reg;
        ev_album_next   = ev_album_reg;
        repaint_next    = repaint_reg;
        mem_we          = 1'b0;
        advance         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    act_next       = action;
                    album_next     = album;
                    centre_next    = centre;
                    art_next       = has_art;
                    idx_next       = '0;
                    have_best_next = 1'b0;
                    mod_r_next     = '0;
                    mod_cnt_next   = '0;
                    hit_next       = 1'b0;
                    slot_next      = '0;
                    ev_valid_next  = 1'b0;
                    ev_album_next  = '0;
                    repaint_next   = 1'b0;
                    priority if (action == ACT_FLUSH)
                    begin
                        valid_next = '0;
                        state_next = ST_DONE;
                    end
                    else if (action == ACT_PROBE)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_CMOD;
                    end
                end
            end

            // Reduce the centre item modulo album_count.
            ST_CMOD:
            begin
                mod_r_next   = mod_val;
                mod_cnt_next = mod_cnt_reg + MOD_CNT_W'(1);
                if (mod_last)
                begin
                    rc_next    = mod_val;
                    state_next = ST_READ;
                end
            end

            ST_READ:
            begin
                state_next = ST_EVAL;
            end

            // Entry word is available: check for a hit, decide what else it needs.
            ST_EVAL:
            begin
                if (idx_reg == '0)
                begin
                    e0_album_next = rd.album;
                end
                if ((act_reg != ACT_DROP) && match)
                begin
                    hit_next   = 1'b1;
                    slot_next  = SLOT_W'(idx_reg);
                    state_next = (act_reg == ACT_LOOKUP) ? ST_WRITE : ST_DONE;
                end
                else if (act_reg == ACT_PROBE)
                begin
                    advance = 1'b1;
                end
                else if (rd_valid && ((act_reg == ACT_LOOKUP) || !rd.has_art))
                begin
                    mod_r_next   = '0;
                    mod_cnt_next = '0;
                    state_next   = ST_EMOD;
                end
                else if (act_reg == ACT_LOOKUP)
                begin
                    state_next = ST_JUDGE;
                end
                else
                begin
                    advance = 1'b1;
                end
            end

            // Reduce the entry item modulo album_count.
            ST_EMOD:
            begin
                mod_r_next   = mod_val;
                mod_cnt_next = mod_cnt_reg + MOD_CNT_W'(1);
                if (mod_last)
                begin
                    state_next = ST_JUDGE;
                end
            end

            // Victim tracking for a lookup, removal for a drop.
            ST_JUDGE:
            begin
                if (act_reg == ACT_LOOKUP)
                begin
                    if (!pinned && (!have_best_reg || (rd.age < best_age_reg)))
                    begin
                        have_best_next  = 1'b1;
                        best_idx_next   = idx_reg;
                        best_age_next   = rd.age;
                        best_valid_next = rd_valid;
                        best_album_next = rd_valid ? rd.album : '0;
                    end
                end
                else
                begin
                    valid_next[idx_reg] = 1'b0;
                    repaint_next        = repaint_reg | pinned;
                end
                advance = 1'b1;
            end

            ST_WRITE:
            begin
                mem_we              = 1'b1;
                valid_next[wr_addr] = 1'b1;
                counter_next        = counter_reg + AGE_W'(1);
                state_next          = ST_DONE;
            end

            ST_DONE:
            begin
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Step to the next entry, or close the scan after the last one.
        if (advance)
        begin
            if (!last)
            begin
                idx_next   = idx_reg + IDX_W'(1);
                state_next = ST_READ;
            end
            else if (act_reg == ACT_LOOKUP)
            begin
                // With every slot pinned, slot 0 is replaced.
                if (have_best_next)
                begin
                    slot_next     = SLOT_W'(best_idx_next);
                    ev_valid_next = best_valid_next;
                    ev_album_next = best_album_next;
                end
                else
                begin
                    slot_next     = '0;
                    ev_valid_next = valid_reg[0];
                    ev_album_next = valid_reg[0] ? e0_album_reg : '0;
                end
                state_next = ST_WRITE;
            end
            else
            begin
                state_next = ST_DONE;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            valid_reg       <= '0;
            written_reg     <= '0;
            counter_reg     <= '0;
            album_count_reg <= COUNT_W'(1);
            mod_cnt_reg     <= '0;
            rd_written_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            valid_reg      <= valid_next;
            counter_reg    <= counter_next;
            mod_cnt_reg    <= mod_cnt_next;
            rd_written_reg <= written_reg[idx_reg];
            if (mem_we)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (cfg_write)
            begin
                album_count_reg <= pwdata[COUNT_W-1:0];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        album_reg      <= album_next;
        centre_reg     <= centre_next;
        art_reg        <= art_next;
        mod_r_reg      <= mod_r_next;
        rc_reg         <= rc_next;
        have_best_reg  <= have_best_next;
        best_idx_reg   <= best_idx_next;
        best_age_reg   <= best_age_next;
        best_valid_reg <= best_valid_next;
        best_album_reg <= best_album_next;
        e0_album_reg   <= e0_album_next;
        hit_reg        <= hit_next;
        slot_reg       <= slot_next;
        ev_valid_reg   <= ev_valid_next;
        ev_album_reg   <= ev_album_next;
        repaint_reg    <= repaint_next;
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ent_mem[wr_addr] <= wr_word;
        end
        rdata_reg <= ent_mem[idx_reg];
    end

    // Result ports.
    assign done          = (state_reg == ST_DONE);
    assign hit           = hit_reg;
    assign slot          = slot_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_album = ev_album_reg;
    assign repaint       = repaint_reg;

    // A flush transaction completes in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (action == ACT_FLUSH)) |=> done)
        else $error("flush did not complete in one cycle");

    // A reported hit names a slot that holds a valid entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit_reg) |-> valid_reg[slot_reg[IDX_W-1:0]])
        else $error("hit reported on an invalid slot");

    // The result strobe lasts a single cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    // A memory write is always followed by the result of its transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |=> (done && valid_reg[slot_reg[IDX_W-1:0]]))
        else $error("write not followed by result with slot valid");

endmodule
